>>> src/cwa_pkg.sv
// shared constants and types for the cascaded window averager
package cwa_pkg;
   localparam int SampleDepth = 4096;
   localparam int MeanDepth   = 32;
   localparam int SampleAw    = $clog2(SampleDepth);
   localparam int MeanAw      = $clog2(MeanDepth);
   localparam int SampleCw    = SampleAw + 1;
   localparam int MeanCw      = MeanAw + 1;
   localparam int SampleSw    = 16 + SampleCw;
   localparam int MeanSw      = 16 + MeanCw;
   localparam int DivW        = SampleSw;
   localparam int DivCw       = $clog2(DivW + 1);

   localparam logic [31:0] ShortWindowReset = 32'd3600;
   localparam logic [31:0] LongWindowReset  = 32'd86400;

   localparam logic CsrShortWindow = 1'b0;
   localparam logic CsrLongWindow  = 1'b1;

   typedef struct packed {
      logic                   start;
      logic [DivW-1:0]        dividend;
      logic [SampleCw-1:0]    divisor;
   } div_req_type;
endpackage

>>> src/cwa_divider.sv
// restoring serial divider, signed dividend by positive divisor, truncating toward zero
module cwa_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  cwa_pkg::div_req_type div_req,
   output logic                 div_done,
   output logic [15:0]          div_quotient
);
   localparam int W  = cwa_pkg::DivW;
   localparam int CW = cwa_pkg::DivCw;

   logic [W-1:0]                  quo_ff, quo_in;
   logic [W:0]                    rem_ff, rem_in;
   logic [cwa_pkg::SampleCw-1:0]  den_ff, den_in;
   logic                          neg_ff, neg_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [W:0]                    shifted;
   logic [W:0]                    trial;
   logic [W-1:0]                  qnext;
   logic [W-1:0]                  qres;

   always_comb begin
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      trial   = shifted - {{(W+1-cwa_pkg::SampleCw){1'b0}}, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      qnext   = {quo_ff[W-2:0], ~trial[W]};
      if (div_req.start) begin
         neg_in  = div_req.dividend[W-1];
         quo_in  = div_req.dividend[W-1] ? (~div_req.dividend + 1'b1) : div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial[W] ? shifted : trial;
         quo_in = qnext;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign qres         = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign div_done     = done_ff;
   assign div_quotient = qres[15:0];
endmodule

>>> src/cascaded_window_averager.sv
// top level of the cascaded window averager
// usage
//  - req channel carries one timestamped q8.8 temperature sample per transaction
//    (req_sample_time, req_temperature); timestamps must not decrease
//  - rsp channel returns one result transaction per request: short and long
//    mean flags and values, a ring overflow flag and an order error flag
//  - csr port writes short_window (index 0) and long_window (index 1) while idle
// timing
//  - one sample at a time; req_stall is high from acceptance until the result
//    register has been loaded and its result taken
//  - the time to a result is set by the eviction walks (one ring entry per cycle through the
//    sample and mean memories' single read port) and by the serial divider,
//    which runs once for each mean that is due
//  - an order error goes from idle through the output state to the result register, nothing changed
// reset and back pressure
//  - reset empties both rings and clears timing state; memories need no clear
//    since entries are read only inside the valid count
//  - the result sits in an output register; while rsp_stall is high it holds,
//    and the next request is taken only after the result has been taken
module cascaded_window_averager (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_time,
   input  logic signed [15:0] req_temperature,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_short_mean_valid,
   output logic signed [15:0] rsp_short_mean,
   output logic        rsp_long_mean_valid,
   output logic signed [15:0] rsp_long_mean,
   output logic        rsp_ring_overflow,
   output logic        rsp_order_error,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   localparam int SAW = cwa_pkg::SampleAw;
   localparam int MAW = cwa_pkg::MeanAw;
   localparam int SCW = cwa_pkg::SampleCw;
   localparam int MCW = cwa_pkg::MeanCw;
   localparam int SSW = cwa_pkg::SampleSw;
   localparam int MSW = cwa_pkg::MeanSw;

   // sequencer states
   localparam logic [3:0] StIdle    = 4'd0;
   localparam logic [3:0] StSRead   = 4'd1;
   localparam logic [3:0] StSCheck  = 4'd2;
   localparam logic [3:0] StSPush   = 4'd3;
   localparam logic [3:0] StMRead   = 4'd4;
   localparam logic [3:0] StMCheck  = 4'd5;
   localparam logic [3:0] StSDue    = 4'd6;
   localparam logic [3:0] StSDiv    = 4'd7;
   localparam logic [3:0] StMPush   = 4'd8;
   localparam logic [3:0] StLDue    = 4'd9;
   localparam logic [3:0] StLDiv    = 4'd10;
   localparam logic [3:0] StOut     = 4'd11;
   localparam logic [3:0] StOvRead  = 4'd12;
   localparam logic [3:0] StMOvRead = 4'd13;

   // sample and mean memories
   logic [31:0] s_time_mem [cwa_pkg::SampleDepth];
   logic [15:0] s_val_mem  [cwa_pkg::SampleDepth];
   logic [31:0] m_time_mem [cwa_pkg::MeanDepth];
   logic [15:0] m_val_mem  [cwa_pkg::MeanDepth];
   logic [31:0] s_rtime;
   logic [15:0] s_rval;
   logic [31:0] m_rtime;
   logic [15:0] m_rval;
   logic [SAW-1:0] s_raddr;
   logic [MAW-1:0] m_raddr;
   logic s_we, m_we;

   logic [3:0]  state_ff, state_in;
   logic [31:0] short_window_ff, long_window_ff;
   logic [31:0] t_ff, t_in;
   logic signed [15:0] v_ff, v_in;
   logic [SAW-1:0] s_head_ff, s_head_in;
   logic [SCW-1:0] s_count_ff, s_count_in;
   logic signed [SSW-1:0] s_sum_ff, s_sum_in;
   logic [31:0] first_sample_ff, first_sample_in;
   logic seen_ff, seen_in;
   logic [31:0] last_sample_ff, last_sample_in;
   logic [MAW-1:0] m_head_ff, m_head_in;
   logic [MCW-1:0] m_count_ff, m_count_in;
   logic signed [MSW-1:0] m_sum_ff, m_sum_in;
   logic [31:0] first_short_ff, first_short_in;
   logic [31:0] last_short_ff, last_short_in;
   logic any_short_ff, any_short_in;
   logic [31:0] last_long_ff, last_long_in;
   logic any_long_ff, any_long_in;
   logic over_ff, over_in;
   logic sv_ff, sv_in, lv_ff, lv_in;
   logic signed [15:0] sm_ff, sm_in, lm_ff, lm_in;
   logic oe_ff, oe_in;
   logic rsp_valid_ff, rsp_valid_in;

   cwa_pkg::div_req_type div_req;
   logic        div_done;
   logic [15:0] div_quotient;

   logic [32:0] s_since, m_since;
   logic [31:0] ref_time;
   logic [32:0] elapsed;

   cwa_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   // window lower bounds, negative means keep everything
   assign s_since = {1'b0, t_ff} - {1'b0, short_window_ff};
   assign m_since = {1'b0, t_ff} - {1'b0, long_window_ff};

   always_comb begin
      state_in        = state_ff;
      t_in            = t_ff;
      v_in            = v_ff;
      s_head_in       = s_head_ff;
      s_count_in      = s_count_ff;
      s_sum_in        = s_sum_ff;
      first_sample_in = first_sample_ff;
      seen_in         = seen_ff;
      last_sample_in  = last_sample_ff;
      m_head_in       = m_head_ff;
      m_count_in      = m_count_ff;
      m_sum_in        = m_sum_ff;
      first_short_in  = first_short_ff;
      last_short_in   = last_short_ff;
      any_short_in    = any_short_ff;
      last_long_in    = last_long_ff;
      any_long_in     = any_long_ff;
      over_in         = over_ff;
      sv_in           = sv_ff;
      lv_in           = lv_ff;
      sm_in           = sm_ff;
      lm_in           = lm_ff;
      oe_in           = oe_ff;
      rsp_valid_in    = rsp_valid_ff;
      s_we            = 1'b0;
      m_we            = 1'b0;
      // oldest entry of each ring is the default read address
      s_raddr         = s_head_ff - s_count_ff[SAW-1:0];
      m_raddr         = m_head_ff - m_count_ff[MAW-1:0];
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      ref_time        = '0;
      elapsed         = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         StIdle: begin
            if (req_valid && !rsp_valid_ff) begin
               t_in    = req_sample_time;
               v_in    = req_temperature;
               over_in = 1'b0;
               sv_in   = 1'b0;
               lv_in   = 1'b0;
               sm_in   = '0;
               lm_in   = '0;
               oe_in   = 1'b0;
               if (seen_ff && req_sample_time < last_sample_ff) begin
                  // out of order transaction: flag and drop
                  oe_in    = 1'b1;
                  state_in = StOut;
               end else begin
                  if (!seen_ff) begin
                     first_sample_in = req_sample_time;
                  end
                  seen_in        = 1'b1;
                  last_sample_in = req_sample_time;
                  state_in       = StSRead;
               end
            end
         end
         StSRead: begin
            // read issued at oldest address
            state_in = StSCheck;
         end
         StSCheck: begin
            if (s_count_ff != '0 && !s_since[32] && s_rtime < s_since[31:0]) begin
               s_sum_in   = s_sum_ff - SSW'(signed'(s_rval));
               s_count_in = s_count_ff - 1'b1;
               s_raddr    = s_head_ff - s_count_in[SAW-1:0];
               state_in   = StSCheck;
            end else begin
               s_raddr  = s_head_ff;
               state_in = StOvRead;
            end
         end
         StOvRead: begin
            // head entry now on the read port for overwrite
            s_raddr  = s_head_ff;
            state_in = StSPush;
         end
         StSPush: begin
            s_raddr = s_head_ff;
            s_we    = 1'b1;
            if (s_count_ff[SCW-1]) begin
               s_sum_in   = s_sum_ff - SSW'(signed'(s_rval)) + SSW'(v_ff);
               over_in    = 1'b1;
            end else begin
               s_sum_in   = s_sum_ff + SSW'(v_ff);
               s_count_in = s_count_ff + 1'b1;
            end
            s_head_in = s_head_ff + 1'b1;
            state_in  = StMRead;
         end
         StMRead: begin
            state_in = StMCheck;
         end
         StMCheck: begin
            if (m_count_ff != '0 && !m_since[32] && m_rtime < m_since[31:0]) begin
               m_sum_in   = m_sum_ff - MSW'(signed'(m_rval));
               m_count_in = m_count_ff - 1'b1;
               m_raddr    = m_head_ff - m_count_in[MAW-1:0];
               state_in   = StMCheck;
            end else begin
               m_raddr  = m_head_ff;
               state_in = StSDue;
            end
         end
         StSDue: begin
            m_raddr  = m_head_ff;
            ref_time = any_short_ff ? last_short_ff : first_sample_ff;
            elapsed  = {1'b0, t_ff} - {1'b0, ref_time};
            if (elapsed[31:0] >= short_window_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = s_sum_ff;
               div_req.divisor  = s_count_ff;
               state_in         = StSDiv;
            end else begin
               state_in = StLDue;
            end
         end
         StSDiv: begin
            m_raddr = m_head_ff;
            if (div_done) begin
               sv_in = 1'b1;
               sm_in = div_quotient;
               if (!any_short_ff) begin
                  first_short_in = t_ff;
               end
               any_short_in  = 1'b1;
               last_short_in = t_ff;
               state_in      = StMOvRead;
            end
         end
         StMOvRead: begin
            m_raddr  = m_head_ff;
            state_in = StMPush;
         end
         StMPush: begin
            m_raddr = m_head_ff;
            m_we    = 1'b1;
            if (m_count_ff[MCW-1]) begin
               m_sum_in = m_sum_ff - MSW'(signed'(m_rval)) + MSW'(sm_ff);
               over_in  = 1'b1;
            end else begin
               m_sum_in   = m_sum_ff + MSW'(sm_ff);
               m_count_in = m_count_ff + 1'b1;
            end
            m_head_in = m_head_ff + 1'b1;
            state_in  = StLDue;
         end
         StLDue: begin
            ref_time = any_long_ff ? last_long_ff : first_short_ff;
            elapsed  = {1'b0, t_ff} - {1'b0, ref_time};
            if (any_short_ff && elapsed[31:0] >= long_window_ff && m_count_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = cwa_pkg::DivW'(m_sum_ff);
               div_req.divisor  = SCW'(m_count_ff);
               state_in         = StLDiv;
            end else begin
               state_in = StOut;
            end
         end
         StLDiv: begin
            if (div_done) begin
               lv_in        = 1'b1;
               lm_in        = div_quotient;
               any_long_in  = 1'b1;
               last_long_in = t_ff;
               state_in     = StOut;
            end
         end
         StOut: begin
            rsp_valid_in = 1'b1;
            state_in     = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (s_we) begin
         s_time_mem[s_head_ff] <= t_ff;
         s_val_mem[s_head_ff]  <= v_ff;
      end
      s_rtime <= s_time_mem[s_raddr];
      s_rval  <= s_val_mem[s_raddr];
      if (m_we) begin
         m_time_mem[m_head_ff] <= t_ff;
         m_val_mem[m_head_ff]  <= sm_ff;
      end
      m_rtime <= m_time_mem[m_raddr];
      m_rval  <= m_val_mem[m_raddr];
   end

   always_ff @(posedge clock) begin
      t_ff  <= t_in;
      v_ff  <= v_in;
      sm_ff <= sm_in;
      lm_ff <= lm_in;
      if (reset) begin
         state_ff        <= StIdle;
         short_window_ff <= cwa_pkg::ShortWindowReset;
         long_window_ff  <= cwa_pkg::LongWindowReset;
         s_head_ff       <= '0;
         s_count_ff      <= '0;
         s_sum_ff        <= '0;
         first_sample_ff <= '0;
         seen_ff         <= 1'b0;
         last_sample_ff  <= '0;
         m_head_ff       <= '0;
         m_count_ff      <= '0;
         m_sum_ff        <= '0;
         first_short_ff  <= '0;
         last_short_ff   <= '0;
         any_short_ff    <= 1'b0;
         last_long_ff    <= '0;
         any_long_ff     <= 1'b0;
         over_ff         <= 1'b0;
         sv_ff           <= 1'b0;
         lv_ff           <= 1'b0;
         oe_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         if (csr_write && csr_index == cwa_pkg::CsrShortWindow) begin
            short_window_ff <= csr_data;
         end
         if (csr_write && csr_index == cwa_pkg::CsrLongWindow) begin
            long_window_ff <= csr_data;
         end
         s_head_ff       <= s_head_in;
         s_count_ff      <= s_count_in;
         s_sum_ff        <= s_sum_in;
         first_sample_ff <= first_sample_in;
         seen_ff         <= seen_in;
         last_sample_ff  <= last_sample_in;
         m_head_ff       <= m_head_in;
         m_count_ff      <= m_count_in;
         m_sum_ff        <= m_sum_in;
         first_short_ff  <= first_short_in;
         last_short_ff   <= last_short_in;
         any_short_ff    <= any_short_in;
         last_long_ff    <= last_long_in;
         any_long_ff     <= any_long_in;
         over_ff         <= over_in;
         sv_ff           <= sv_in;
         lv_ff           <= lv_in;
         oe_ff           <= oe_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // a request is taken only in idle with the result register empty
   assign req_stall            = (state_ff != StIdle) || rsp_valid_ff;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_short_mean_valid = sv_ff;
   assign rsp_short_mean       = sm_ff;
   assign rsp_long_mean_valid  = lv_ff;
   assign rsp_long_mean        = lm_ff;
   assign rsp_ring_overflow    = over_ff;
   assign rsp_order_error      = oe_ff;
endmodule

>>> tb/cwa_checker.sv
// checker for the cascaded window averager: predicts each result and compares it
`timescale 1ns / 100ps

module cwa_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [31:0]        req_sample_time,
   input  logic signed [15:0] req_temperature,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_short_mean_valid,
   input  logic signed [15:0] rsp_short_mean,
   input  logic               rsp_long_mean_valid,
   input  logic signed [15:0] rsp_long_mean,
   input  logic               rsp_ring_overflow,
   input  logic               rsp_order_error,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending,
   output int                 short_means_seen,
   output int                 long_means_seen,
   output int                 overflows_seen
);

   typedef struct packed {
      bit                 short_ok;
      logic signed [15:0] short_avg;
      bit                 long_ok;
      logic signed [15:0] long_avg;
      bit                 overflow;
      bit                 order_err;
   } avg_result_type;

   avg_result_type expected_avgs[$];

   logic [31:0] short_win, long_win;

   logic [31:0] smp_time[cwa_pkg::SampleDepth];
   int          smp_val[cwa_pkg::SampleDepth];
   int          smp_head, smp_cnt;
   longint      smp_sum;
   logic [31:0] first_smp_t, last_smp_t;
   bit          seen_smp;

   logic [31:0] avg_time[cwa_pkg::MeanDepth];
   int          avg_val[cwa_pkg::MeanDepth];
   int          avg_head, avg_cnt;
   longint      avg_sum;
   logic [31:0] first_short_t, last_short_t, last_long_t;
   bit          seen_short, seen_long;

   function automatic void clear_state();
      short_win = cwa_pkg::ShortWindowReset;
      long_win  = cwa_pkg::LongWindowReset;
      smp_head = 0; smp_cnt = 0; smp_sum = 0;
      first_smp_t = 0; last_smp_t = 0; seen_smp = 0;
      avg_head = 0; avg_cnt = 0; avg_sum = 0;
      first_short_t = 0; last_short_t = 0; last_long_t = 0;
      seen_short = 0; seen_long = 0;
   endfunction

   function automatic avg_result_type predict_averages(logic [31:0] t,
                                                       logic signed [15:0] v);
      avg_result_type r;
      longint         since;
      int             tail;
      logic [31:0]    ref_t;
      r = '0;
      if (seen_smp && t < last_smp_t) begin
         r.order_err = 1;
         return r;
      end
      if (!seen_smp) begin
         seen_smp = 1;
         first_smp_t = t;
      end
      last_smp_t = t;

      // drop samples that fell out of the short window
      since = longint'(t) - longint'(short_win);
      while (smp_cnt > 0) begin
         tail = (smp_head + cwa_pkg::SampleDepth - smp_cnt) % cwa_pkg::SampleDepth;
         if (longint'(smp_time[tail]) >= since) break;
         smp_sum -= smp_val[tail];
         smp_cnt--;
      end
      if (smp_cnt >= cwa_pkg::SampleDepth) begin
         smp_sum -= smp_val[smp_head];
         smp_cnt = cwa_pkg::SampleDepth - 1;
         r.overflow = 1;
      end
      smp_time[smp_head] = t;
      smp_val[smp_head]  = int'(v);
      smp_sum += int'(v);
      smp_cnt++;
      smp_head = (smp_head + 1) % cwa_pkg::SampleDepth;

      since = longint'(t) - longint'(long_win);
      while (avg_cnt > 0) begin
         tail = (avg_head + cwa_pkg::MeanDepth - avg_cnt) % cwa_pkg::MeanDepth;
         if (longint'(avg_time[tail]) >= since) break;
         avg_sum -= avg_val[tail];
         avg_cnt--;
      end

      ref_t = seen_short ? last_short_t : first_smp_t;
      if (longint'(t) - longint'(ref_t) >= longint'(short_win) && smp_cnt > 0) begin
         r.short_avg = 16'(smp_sum / longint'(smp_cnt));
         r.short_ok  = 1;
         if (!seen_short) first_short_t = t;
         seen_short   = 1;
         last_short_t = t;
         if (avg_cnt >= cwa_pkg::MeanDepth) begin
            avg_sum -= avg_val[avg_head];
            avg_cnt = cwa_pkg::MeanDepth - 1;
            r.overflow = 1;
         end
         avg_time[avg_head] = t;
         avg_val[avg_head]  = int'(r.short_avg);
         avg_sum += int'(r.short_avg);
         avg_cnt++;
         avg_head = (avg_head + 1) % cwa_pkg::MeanDepth;
      end

      if (seen_short) begin
         ref_t = seen_long ? last_long_t : first_short_t;
         if (longint'(t) - longint'(ref_t) >= longint'(long_win) && avg_cnt > 0) begin
            r.long_avg = 16'(avg_sum / longint'(avg_cnt));
            r.long_ok  = 1;
            seen_long   = 1;
            last_long_t = t;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      avg_result_type exp_r;
      avg_result_type got;
      if (reset) begin
         clear_state();
         expected_avgs.delete();
         fail_count = 0;
         short_means_seen = 0;
         long_means_seen = 0;
         overflows_seen = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == cwa_pkg::CsrShortWindow) short_win = csr_data;
            else if (csr_index == cwa_pkg::CsrLongWindow) long_win = csr_data;
         end
         if (req_valid && !req_stall)
            expected_avgs.insert(expected_avgs.size(),
                                 predict_averages(req_sample_time, req_temperature));
         if (rsp_valid && !rsp_stall) begin
            got.short_ok  = rsp_short_mean_valid;
            got.short_avg = rsp_short_mean;
            got.long_ok   = rsp_long_mean_valid;
            got.long_avg  = rsp_long_mean;
            got.overflow  = rsp_ring_overflow;
            got.order_err = rsp_order_error;
            short_means_seen += got.short_ok;
            long_means_seen  += got.long_ok;
            overflows_seen   += got.overflow;
            if (expected_avgs.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result transaction at %0t", $realtime);
            end else begin
               exp_r = expected_avgs[0];
               expected_avgs.delete(0);
               if (got !== exp_r) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch at %0t: expected s=%0b/%0d l=%0b/%0d ov=%0b oe=%0b",
                              $realtime, exp_r.short_ok, exp_r.short_avg, exp_r.long_ok,
                              exp_r.long_avg, exp_r.overflow, exp_r.order_err);
                     $display("   got s=%0b/%0d l=%0b/%0d ov=%0b oe=%0b",
                              got.short_ok, got.short_avg, got.long_ok,
                              got.long_avg, got.overflow, got.order_err);
                  end
               end
            end
         end
      end
      pending = expected_avgs.size();
   end

endmodule

>>> tb/tb_cascaded_window_averager.sv
// top of the cascaded window averager testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_cascaded_window_averager;

   localparam int CycleLimit = 2000000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [31:0]        req_sample_time = 0;
   logic signed [15:0] req_temperature = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_short_mean_valid;
   logic signed [15:0] rsp_short_mean;
   logic               rsp_long_mean_valid;
   logic signed [15:0] rsp_long_mean;
   logic               rsp_ring_overflow;
   logic               rsp_order_error;
   logic               csr_write = 0;
   logic               csr_index = cwa_pkg::CsrShortWindow;
   logic [31:0]        csr_data = 0;

   int fail_count, pending, short_means_seen, long_means_seen, overflows_seen;

   // idle odds in percent, set per stretch of the run
   int tx_idle_pct = 16;
   int rx_idle_pct = 73;
   int hold_go = 0;
   int hold_left = 0;
   int samples_sent = 0;
   int order_errs_sent = 0;
   int settings_used = 1;
   int cycles = 0;
   logic [31:0] now_s = 0;

   always #5 clock = ~clock;

   cascaded_window_averager dut (.*);

   cwa_checker checker_i (.*);

   // receiver side: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else if (hold_go != 0) begin
         hold_go = 0;
         hold_left = 300;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // one sample transaction; returns at the edge where it was taken
   task automatic send_sample(input logic [31:0] t, input logic signed [15:0] v);
      // idle pattern follows the position in the run
      if (samples_sent < 300) begin
         tx_idle_pct = 16; rx_idle_pct = 73;
      end else if (samples_sent < 600) begin
         tx_idle_pct = 73; rx_idle_pct = 16;
      end else begin
         tx_idle_pct = 0; rx_idle_pct = 0;
      end
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_sample_time <= t;
      req_temperature <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   // stop sending and wait until every result is back
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // order errors answer early, so give the block time to settle
      repeat (20) @(posedge clock);
   endtask

   task automatic set_windows(input logic [31:0] short_w, input logic [31:0] long_w);
      drain();
      csr_write <= 1; csr_index <= cwa_pkg::CsrShortWindow; csr_data <= short_w;
      @(posedge clock);
      csr_index <= cwa_pkg::CsrLongWindow; csr_data <= long_w;
      @(posedge clock);
      csr_write <= 0;
      settings_used++;
   endtask

   function automatic logic signed [15:0] pick_temperature();
      if ($urandom_range(3) == 0) return 16'($urandom);
      return 16'(2000 + $urandom_range(0, 1024));
   endfunction

   // random stretch: mostly ordered samples, a few stepping back in time
   task automatic run_random(input int count, input int max_step, input int err_pct);
      int          step;
      logic [31:0] back;
      for (int i = 0; i < count; i++) begin
         if (now_s > 0 && $urandom_range(99) < err_pct) begin
            back = now_s - $urandom_range(1, (now_s < 1000) ? now_s : 1000);
            order_errs_sent++;
            send_sample(back, pick_temperature());
         end else begin
            step = $urandom_range(0, max_step);
            now_s = (now_s > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : now_s + step;
            send_sample(now_s, pick_temperature());
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset windows, first sample at time zero, extreme temperatures
      send_sample(0, 0);
      send_sample(0, 16'sh7FFF);
      send_sample(0, -16'sh8000);
      send_sample(100, 1);
      send_sample(3600, 256);          // first short mean due
      send_sample(10, 5);              // time goes backwards
      order_errs_sent++;
      send_sample(3600, -1);           // equal time is fine
      send_sample(7200, -16'sh8000);
      send_sample(7201, 16'sh7FFF);
      send_sample(100000, 16'sh7FFF);  // long mean due, short ring emptied
      send_sample(100000, -16'sh8000);
      send_sample(186400, 0);
      send_sample(190000, -300);
      send_sample(276400, 300);
      now_s = 276400;

      // receiver holds off while samples keep coming so the block backs up
      hold_go = 1;
      run_random(20, 100, 0);
      run_random(130, 1200, 3);

      // zero short window: a mean per sample, mean ring overflows
      set_windows(0, 100);
      run_random(200, 3, 3);
      // short window longer than long one: empty long window case
      set_windows(50, 10);
      run_random(75, 30, 3);
      drain();                         // sender waits out every result
      run_random(75, 30, 3);
      set_windows(1, 32'hFFFF_FFFF);
      run_random(100, 5, 3);
      set_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(100, 100000, 3);

      // pile samples onto one timestamp, then evict the whole ring in one walk
      for (int i = 0; i < 20; i++) send_sample(now_s, pick_temperature());
      set_windows(1, 1);
      now_s += 10;
      send_sample(now_s, pick_temperature());

      // high timestamps up to the top of the range
      set_windows(1000, 5000);
      now_s = 32'h8000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
      run_random(100, 2000, 3);
      now_s = 32'hFFFF_0000;
      run_random(20, 8000, 3);
      for (int i = 0; i < 5; i++) send_sample(32'hFFFF_FFFF, pick_temperature());
      now_s = 32'hFFFF_FFFF;

      drain();
      repeat (200) @(posedge clock);

      $display("covered %0d samples (%0d out of order) over %0d window settings",
               samples_sent, order_errs_sent, settings_used);
      $display("saw %0d short means, %0d long means, %0d ring overflows",
               short_means_seen, long_means_seen, overflows_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> sim.f
src/cwa_pkg.sv
src/cwa_divider.sv
src/cascaded_window_averager.sv
tb/cwa_checker.sv
tb/tb_cascaded_window_averager.sv
